// File: hdl/rgbhsv_pkg.sv
// Types, widths and constants for the RGB to HSV converter.
// No dependencies; imported by rgb_to_hsv_converter_core.
package rgbhsv_pkg;

	localparam int HUE_FRAC_BITS = 6;
	localparam int SAT_FRAC_BITS = 15;

	localparam int PIX_W = 8;
	localparam int HUE_W = 15;
	localparam int SAT_W = 16;

	localparam int S_TDATA_W = ((3 * PIX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((HUE_W + SAT_W + PIX_W + 7) / 8) * 8;

	// hue quotient is 60 * mag * 2^HUE_FRAC_BITS / delta with mag <= delta
	localparam int HUE_SCALE = 60 << HUE_FRAC_BITS;
	localparam int HUE_QW    = $clog2(HUE_SCALE + 1);
	localparam int HUE_NUM_W = PIX_W + HUE_QW;

	// saturation quotient is delta * 2^SAT_FRAC_BITS / max with delta <= max
	localparam int SAT_QW    = SAT_FRAC_BITS + 1;
	localparam int SAT_NUM_W = PIX_W + SAT_FRAC_BITS;

	localparam int DIV_STEPS = (HUE_QW > SAT_QW) ? HUE_QW : SAT_QW;

	localparam int HUE_TURN  = 360 << HUE_FRAC_BITS;
	localparam int HUE_GREEN = 120 << HUE_FRAC_BITS;
	localparam int HUE_BLUE  = 240 << HUE_FRAC_BITS;
	localparam int HUE_CW    = $clog2(HUE_TURN + 1) + 1;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [PIX_W-1:0] delta;
		logic [PIX_W-1:0] mag;
		logic             neg;
		sector_t          sector;
	} prep_t;

	typedef struct packed {
		logic [PIX_W-1:0]  value;
		logic [PIX_W-1:0]  delta;
		logic              neg;
		sector_t           sector;
		logic [PIX_W-1:0]  hue_rem;
		logic [HUE_QW-1:0] hue_acc;
		logic [PIX_W-1:0]  sat_rem;
		logic [SAT_QW-1:0] sat_acc;
	} div_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [SAT_W-1:0] sat;
		logic [HUE_W-1:0] hue;
	} res_t;

endpackage

// File: hdl/rgb_to_hsv_converter_core.sv
// RGB to HSV converter: min/max stage, two restoring dividers one bit per stage, output stage.
// Depends on rgbhsv_pkg.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: blue [7:0], green [15:8], red [23:16]
//  m_*       out  m_tvalid/m_tready  m_tdata: hue [14:0], sat [30:15], value [38:31]
//
// One pixel per clock while m_tready allows; DIV_STEPS divider stages, set by the
// sixteen quotient bits of the saturation divider, one bit per pipeline stage.
// Reset clears all valid bits; payload registers are not reset.
// Each stage advances when empty or when the next one advances, so bubbles close up
// and input is taken while a finished result waits on m_tready if an earlier stage is empty.
module rgb_to_hsv_converter_core
	import rgbhsv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // blue, green, red
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // hue, sat, value, zero pad
);

	logic [PIX_W-1:0] blue, green, red;
	logic [PIX_W-1:0] mx, mn, pa, pb;
	prep_t            prep_d;

	prep_t            prep_s1;
	logic             prep_v_s1;
	logic             prep_rdy;

	div_t             div_s2   [DIV_STEPS];
	logic             div_v_s2 [DIV_STEPS];
	div_t             div_d    [DIV_STEPS];
	logic             div_rdy  [DIV_STEPS];

	res_t             res_d;
	res_t             out_q;
	logic             out_v_q;
	logic             out_rdy;

	logic [HUE_CW-1:0] basef, qh, hue_c;

	assign blue  = s_tdata[PIX_W-1:0];
	assign green = s_tdata[2*PIX_W-1:PIX_W];
	assign red   = s_tdata[3*PIX_W-1:2*PIX_W];

	// ready chain, last stage first
	assign out_rdy = !out_v_q || m_tready;
	always_comb begin
		for (int i = DIV_STEPS - 1; i >= 0; i--) begin
			if (i == DIV_STEPS - 1)
				div_rdy[i] = !div_v_s2[i] || out_rdy;
			else
				div_rdy[i] = !div_v_s2[i] || div_rdy[i+1];
		end
	end
	assign prep_rdy = !prep_v_s1 || div_rdy[0];
	assign s_tready = prep_rdy;

	// max, min, sector and signed difference
	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;

		if (mx == red) begin
			prep_d.sector = SECT_RED;
			pa = green;
			pb = blue;
		end else if (mx == green) begin
			prep_d.sector = SECT_GREEN;
			pa = blue;
			pb = red;
		end else begin
			prep_d.sector = SECT_BLUE;
			pa = red;
			pb = green;
		end

		prep_d.value = mx;
		prep_d.delta = mx - mn;
		prep_d.neg   = pa < pb;
		prep_d.mag   = (pa < pb) ? pb - pa : pa - pb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_v_s1 <= 1'b0;
		end else if (prep_rdy) begin
			prep_v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (prep_rdy && s_tvalid) begin
			prep_s1 <= prep_d;
		end
	end

	// divider stages: one saturation quotient bit per stage, one hue quotient bit in each of the first HUE_QW stages
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		div_t             cur;
		logic [PIX_W:0]   h_trial, s_trial;
		logic             h_ge, s_ge;
		logic [HUE_NUM_W-1:0] hnum;
		logic [SAT_NUM_W-1:0] snum;
		logic             in_v;
		logic             adv;

		always_comb begin
			hnum = '0;
			snum = '0;
			if (i == 0) begin
				hnum = HUE_NUM_W'(prep_s1.mag) * HUE_NUM_W'(HUE_SCALE);
				snum = {prep_s1.delta, {SAT_FRAC_BITS{1'b0}}};
				cur.value   = prep_s1.value;
				cur.delta   = prep_s1.delta;
				cur.neg     = prep_s1.neg;
				cur.sector  = prep_s1.sector;
				cur.hue_rem = hnum[HUE_NUM_W-1:HUE_QW];
				cur.hue_acc = hnum[HUE_QW-1:0];
				cur.sat_rem = PIX_W'(snum >> SAT_QW);
				cur.sat_acc = snum[SAT_QW-1:0];
			end else begin
				cur = div_s2[(i == 0) ? 0 : i - 1];
			end

			div_d[i] = cur;

			h_trial = {cur.hue_rem, cur.hue_acc[HUE_QW-1]};
			h_ge    = h_trial >= {1'b0, cur.delta};
			if (i < HUE_QW) begin
				div_d[i].hue_rem = h_ge ? PIX_W'(h_trial - {1'b0, cur.delta})
				                        : PIX_W'(h_trial);
				div_d[i].hue_acc = {cur.hue_acc[HUE_QW-2:0], h_ge};
			end

			s_trial = {cur.sat_rem, cur.sat_acc[SAT_QW-1]};
			s_ge    = s_trial >= {1'b0, cur.value};
			if (i < SAT_QW) begin
				div_d[i].sat_rem = s_ge ? PIX_W'(s_trial - {1'b0, cur.value})
				                        : PIX_W'(s_trial);
				div_d[i].sat_acc = {cur.sat_acc[SAT_QW-2:0], s_ge};
			end
		end

		assign in_v = (i == 0) ? prep_v_s1 : div_v_s2[(i == 0) ? 0 : i - 1];
		assign adv  = div_rdy[i];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s2[i] <= 1'b0;
			end else if (adv) begin
				div_v_s2[i] <= in_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv && in_v) begin
				div_s2[i] <= div_d[i];
			end
		end
	end

	// sector base, sign and wrap
	always_comb begin
		case (div_s2[DIV_STEPS-1].sector)
			SECT_RED:   basef = '0;
			SECT_GREEN: basef = HUE_CW'(HUE_GREEN);
			SECT_BLUE:  basef = HUE_CW'(HUE_BLUE);
			default:    basef = '0;
		endcase
		qh = HUE_CW'(div_s2[DIV_STEPS-1].hue_acc);

		if (div_s2[DIV_STEPS-1].delta == '0)
			hue_c = '0;
		else if (!div_s2[DIV_STEPS-1].neg)
			hue_c = basef + qh;
		else if (qh <= basef)
			hue_c = basef - qh;
		else
			hue_c = HUE_CW'(HUE_TURN) + basef - qh;

		res_d.hue   = hue_c[HUE_W-1:0];
		res_d.sat   = (div_s2[DIV_STEPS-1].value == '0) ? '0
		              : SAT_W'(div_s2[DIV_STEPS-1].sat_acc);
		res_d.value = div_s2[DIV_STEPS-1].value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_rdy) begin
			out_v_q <= div_v_s2[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && div_v_s2[DIV_STEPS-1]) begin
			out_q <= res_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = M_TDATA_W'({out_q.value, out_q.sat, out_q.hue});

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Stream testbench for rgb_to_hsv_converter_core: BGR pixels in, hue/sat/value out.
// Depends on rgbhsv_pkg and the core; a scoreboard predicts each pixel's HSV result.

module tb_top;
	import rgbhsv_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;
	localparam int PHASE_ITEMS = 460;
	localparam int MAX_PRINTS  = 60;

	class hsv_scoreboard;
		res_t hsv_expected[$];
		int   mismatches;

		function new();
			mismatches = 0;
		endfunction

		function res_t predict_hsv(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
				logic [PIX_W-1:0] r);
			int unsigned mx, mn, delta, pa, pb, mag, q, basef, hue, sat, one_deg;
			int unsigned bi, gi, ri;
			sector_t sect;
			bit neg;
			res_t res;
			bi = 32'(b);
			gi = 32'(g);
			ri = 32'(r);
			one_deg = 1 << HUE_FRAC_BITS;
			mx = ri;
			mn = ri;
			if (gi > mx) mx = gi;
			if (bi > mx) mx = bi;
			if (gi < mn) mn = gi;
			if (bi < mn) mn = bi;
			delta = mx - mn;
			hue = 0;
			if (delta != 0) begin
				if (mx == ri) sect = SECT_RED;
				else if (mx == gi) sect = SECT_GREEN;
				else sect = SECT_BLUE;
				case (sect)
					SECT_RED: begin
						pa = gi; pb = bi; basef = 0;
					end
					SECT_GREEN: begin
						pa = bi; pb = ri; basef = 120 * one_deg;
					end
					default: begin
						pa = ri; pb = gi; basef = 240 * one_deg;
					end
				endcase
				neg = pa < pb;
				mag = neg ? pb - pa : pa - pb;
				q = (60 * mag * one_deg) / delta;
				if (!neg) hue = basef + q;
				else if (q <= basef) hue = basef - q;
				else hue = 360 * one_deg - (q - basef);
			end
			sat = (mx != 0) ? (delta << SAT_FRAC_BITS) / mx : 0;
			res.hue   = hue[HUE_W-1:0];
			res.sat   = sat[SAT_W-1:0];
			res.value = mx[PIX_W-1:0];
			return res;
		endfunction

		function void note_pixel(logic [S_TDATA_W-1:0] px);
			hsv_expected.push_back(predict_hsv(px[7:0], px[15:8], px[23:16]));
		endfunction

		task report_mismatch(string what, int got, int want);
			if (mismatches < MAX_PRINTS)
				$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
			mismatches++;
		endtask

		task check_result(logic [M_TDATA_W-1:0] data);
			res_t got, want;
			got = res_t'(data[HUE_W+SAT_W+PIX_W-1:0]);
			if (hsv_expected.size() == 0) begin
				report_mismatch("unexpected result, hue", int'(got.hue), 0);
				return;
			end
			want = hsv_expected.pop_front();
			if (got.hue !== want.hue)
				report_mismatch("hue", int'(got.hue), int'(want.hue));
			if (got.sat !== want.sat)
				report_mismatch("sat", int'(got.sat), int'(want.sat));
			if (got.value !== want.value)
				report_mismatch("value", int'(got.value), int'(want.value));
		endtask

		function int pending();
			return hsv_expected.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // blue, green, red
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // hue, sat, value, zero pad

	hsv_scoreboard sb = new();
	int idle_pct;
	int stall_pct;
	int cycles;

	rgb_to_hsv_converter_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99, 0) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		while ($urandom_range(99, 0) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r, g, b};
		do @(posedge clk); while (!s_tready);
	endtask

	task drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function logic [23:0] random_pixel();
		logic [7:0] a, b, c;
		int kind;
		kind = $urandom_range(99, 0);
		a = 8'($urandom_range(255, 0));
		b = 8'($urandom_range(255, 0));
		c = 8'($urandom_range(255, 0));
		if (kind < 50) return {a, b, c};
		if (kind < 62) return {a, a, a};
		if (kind < 70) return {a, a, b};
		if (kind < 78) return {a, b, a};
		if (kind < 86) return {b, a, a};
		if (kind < 93) return {6'd0, a[1:0], 6'd0, b[1:0], 6'd0, c[1:0]};
		return {8'hff, b, 8'h00} >> (8 * $urandom_range(1, 0));
	endfunction

	task random_phase(int n);
		logic [23:0] px;
		repeat (n) begin
			px = random_pixel();
			if (px[23:16] == 0 && px[15:8] == 0 && px[7:0] < 4 && $urandom_range(1, 0))
				px = {6'd0, px[17:16], 6'd0, px[9:8], 6'd0, px[1:0]} |
				     24'($urandom_range(3, 0));
			send_pixel(px[7:0], px[15:8], px[23:16]);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		cycles    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black, white, grey, primaries and secondaries
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		// red sector wrapping below zero, smallest and largest fraction
		send_pixel(8'd1, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd3, 8'd201);
		// negative differences in green and blue sectors
		send_pixel(8'd0, 8'd255, 8'd1);
		send_pixel(8'd255, 8'd1, 8'd0);
		send_pixel(8'd10, 8'd250, 8'd200);
		send_pixel(8'd250, 8'd200, 8'd10);
		// ties for the largest channel
		send_pixel(8'd7, 8'd99, 8'd99);
		send_pixel(8'd99, 8'd99, 8'd7);
		send_pixel(8'd99, 8'd7, 8'd99);
		// tiny values, a single low bit and one mid-range pixel
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd2, 8'd1, 8'd0);
		send_pixel(8'd170, 8'd85, 8'd255);
		random_phase(PHASE_ITEMS - 24);
		drain_results();

		idle_pct = 77;
		random_phase(PHASE_ITEMS);
		drain_results();

		idle_pct  = 0;
		stall_pct = 77;
		random_phase(PHASE_ITEMS);
		drain_results();

		idle_pct  = 30;
		stall_pct = 30;
		random_phase(PHASE_ITEMS);
		drain_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule
